// ----- rtl/multilevel_priority_task_dispatcher_assert.svh -----
// Assertion macros for the task dispatcher checks.
`ifndef MULTILEVEL_PRIORITY_TASK_DISPATCHER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_TASK_DISPATCHER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define MPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mpd_pkg.sv -----
// Shared constants, types and helpers of the task dispatcher.
`timescale 1ns / 1ps

package mpd_pkg;

    // Sizing
    localparam int TASK_SLOTS      = 64;
    localparam int PRIORITY_LEVELS = 3;
    localparam int QUEUE_COUNT     = PRIORITY_LEVELS + 2;
    localparam int TASK_W          = $clog2(TASK_SLOTS);
    localparam int LVL_W           = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int QIDX_W          = $clog2(QUEUE_COUNT);

    // Transaction field widths
    localparam int CMD_W = 3;
    localparam int TID_W = 6;
    localparam int PRI_W = 2;
    localparam int PC_W  = 32;
    localparam int ST_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADMIT   = 3'd0,
        CMD_PREEMPT = 3'd1,
        CMD_IO_WAIT = 3'd2,
        CMD_IO_DONE = 3'd3,
        CMD_BLOCK   = 3'd4,
        CMD_FINISH  = 3'd5,
        CMD_QUERY   = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_IO_EMPTY  = 2'd2
    } t_status;

    typedef logic [TASK_W-1:0] t_slot;

    // Accepted command transaction
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TID_W-1:0] task_id;
        logic [PRI_W-1:0] task_priority;
        logic             device;
        logic [PC_W-1:0]  cpu_pc;
    } t_item;

    // Queue pointers and the running task
    typedef struct packed {
        logic [QUEUE_COUNT-1:0][TASK_W-1:0] head;
        logic [QUEUE_COUNT-1:0][TASK_W-1:0] tail;
        logic [QUEUE_COUNT-1:0]             ne;
        t_slot                              cur_task;
        logic                               cur_idle;
    } t_sched;

    // Read addresses of the task tables
    typedef struct packed {
        t_slot link;
        t_slot pc;
        t_slot pri;
    } t_rd_addr;

    // Write requests to the task tables
    typedef struct packed {
        logic             link_we;
        t_slot            link_addr;
        t_slot            link_data;
        logic             pc_we;
        t_slot            pc_addr;
        logic [PC_W-1:0]  pc_data;
        logic             pri_we;
        t_slot            pri_addr;
        logic [PRI_W-1:0] pri_data;
    } t_wr;

    // Response transaction
    typedef struct packed {
        logic [TID_W-1:0] running_task;
        logic             running_idle;
        logic [PC_W-1:0]  resume_pc;
        logic             switched;
        logic [ST_W-1:0]  status;
    } t_result;

    // Saturate a priority to the lowest level
    function automatic logic [LVL_W-1:0] clamp_level(input logic [PRI_W-1:0] p);
        logic [LVL_W-1:0] lv;
        if (int'(p) >= PRIORITY_LEVELS) begin
            lv = LVL_W'(PRIORITY_LEVELS - 1);
        end else begin
            lv = LVL_W'(p);
        end
        return lv;
    endfunction

endpackage

// ----- rtl/mpd_if.sv -----
// Command and response channel interfaces of the task dispatcher.
`timescale 1ns / 1ps

interface mpd_cmd_if
    import mpd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [TID_W-1:0] task_id;
    logic [PRI_W-1:0] task_priority;
    logic             device;
    logic [PC_W-1:0]  cpu_pc;

    modport source (output valid, command, task_id, task_priority, device, cpu_pc,
                    input ready);
    modport sink   (input valid, command, task_id, task_priority, device, cpu_pc,
                    output ready);
endinterface

interface mpd_rsp_if
    import mpd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TID_W-1:0] running_task;
    logic             running_idle;
    logic [PC_W-1:0]  resume_pc;
    logic             switched;
    logic [ST_W-1:0]  status;

    modport source (output valid, running_task, running_idle, resume_pc, switched, status,
                    input ready);
    modport sink   (input valid, running_task, running_idle, resume_pc, switched, status,
                    output ready);
endinterface

// ----- rtl/multilevel_priority_task_dispatcher.sv -----
// Multilevel priority task dispatcher: top level with sequencer, tables and result register.
`timescale 1ns / 1ps

// Each command transaction passes through a read state, which reads the link,
// saved-pc and priority tables (registered RAM reads addressed by the queue
// heads and the running task), and an execute state, which decodes the command,
// updates the queue pointers, writes the tables and loads the result register.
// A new command is taken in the cycle its predecessor finishes, so commands do
// not overlap; a full, untaken result register holds the finishing transaction
// back. Level 0 is served first; with every ready queue empty the idle task
// runs from pc zero. After reset the idle task runs and all queues are empty;
// the task tables are not cleared and hold valid data only where a task was
// admitted.
`include "multilevel_priority_task_dispatcher_assert.svh"

module multilevel_priority_task_dispatcher
    import mpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mpd_cmd_if.sink   i_cmd,
    mpd_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_item            r_item;
    t_sched           r_sched;
    t_sched           n_sched;
    logic             r_out_valid;
    t_result          r_result;
    t_result          w_result;
    t_rd_addr         w_rd_addr;
    t_wr              w_wr;
    t_slot            w_rd_link;
    logic [PC_W-1:0]  w_rd_pc;
    logic [PRI_W-1:0] w_rd_pri;
    logic             w_exec_go;
    logic             w_accept;

    // Finish when the result register is free or being drained
    assign w_exec_go = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = (r_state == S_IDLE) || w_exec_go;
    assign w_accept  = i_cmd.valid && i_cmd.ready;

    // Sequence read and execute cycles
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec_go) begin
                    n_state = w_accept ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the command transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.command       <= i_cmd.command;
            r_item.task_id       <= i_cmd.task_id;
            r_item.task_priority <= i_cmd.task_priority;
            r_item.device        <= i_cmd.device;
            r_item.cpu_pc        <= i_cmd.cpu_pc;
        end
    end

    // Task tables
    mpd_ram #(.WIDTH(TASK_W), .DEPTH(TASK_SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_exec_go && w_wr.link_we),
        .i_waddr (w_wr.link_addr),
        .i_wdata (w_wr.link_data),
        .i_raddr (w_rd_addr.link),
        .o_rdata (w_rd_link)
    );

    mpd_ram #(.WIDTH(PC_W), .DEPTH(TASK_SLOTS)) u_pc_ram (
        .i_clk   (i_clk),
        .i_we    (w_exec_go && w_wr.pc_we),
        .i_waddr (w_wr.pc_addr),
        .i_wdata (w_wr.pc_data),
        .i_raddr (w_rd_addr.pc),
        .o_rdata (w_rd_pc)
    );

    mpd_ram #(.WIDTH(PRI_W), .DEPTH(TASK_SLOTS)) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (w_exec_go && w_wr.pri_we),
        .i_waddr (w_wr.pri_addr),
        .i_wdata (w_wr.pri_data),
        .i_raddr (w_rd_addr.pri),
        .o_rdata (w_rd_pri)
    );

    mpd_exec u_exec (
        .i_item    (r_item),
        .i_sched   (r_sched),
        .i_rd_link (w_rd_link),
        .i_rd_pc   (w_rd_pc),
        .i_rd_pri  (w_rd_pri),
        .o_rd_addr (w_rd_addr),
        .o_sched   (n_sched),
        .o_wr      (w_wr),
        .o_result  (w_result)
    );

    // Commit queue pointers and running task
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched.head     <= '0;
            r_sched.tail     <= '0;
            r_sched.ne       <= '0;
            r_sched.cur_task <= '0;
            r_sched.cur_idle <= 1'b1;
        end else if (w_exec_go) begin
            r_sched <= n_sched;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_result <= w_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.running_task = r_result.running_task;
    assign o_rsp.running_idle = r_result.running_idle;
    assign o_rsp.resume_pc    = r_result.resume_pc;
    assign o_rsp.switched     = r_result.switched;
    assign o_rsp.status       = r_result.status;

    // Checks
    `MPD_ASSERT_NEXT(a_accept_reads, w_accept, r_state == S_READ, "accepted command did not start a table read")
    `MPD_ASSERT_NEXT(a_read_execs, r_state == S_READ, r_state == S_EXEC, "table read not followed by execute")
    `MPD_ASSERT_NEXT(a_exec_loads, w_exec_go, r_out_valid, "finished command left no result")
    `MPD_ASSERT_NOW(a_idle_slot, r_sched.cur_idle, r_sched.cur_task == '0, "idle task with nonzero slot")

endmodule

// ----- rtl/mpd_ram.sv -----
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps

module mpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on request, register every read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mpd_exec.sv -----
// Command decode, queue update and dispatch logic for one transaction.
`timescale 1ns / 1ps

module mpd_exec
    import mpd_pkg::*;
(
    input  t_item            i_item,
    input  t_sched           i_sched,
    input  t_slot            i_rd_link,
    input  logic [PC_W-1:0]  i_rd_pc,
    input  logic [PRI_W-1:0] i_rd_pri,
    output t_rd_addr         o_rd_addr,
    output t_sched           o_sched,
    output t_wr              o_wr,
    output t_result          o_result
);

    logic [QIDX_W-1:0] w_dq;
    logic [LVL_W-1:0]  w_l0;
    t_slot             w_tid;
    t_slot             w_cur;

    // Pick the lowest-numbered non-empty ready level before any push
    always_comb begin
        w_l0 = '0;
        for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
            if (i_sched.ne[l]) begin
                w_l0 = LVL_W'(l);
            end
        end
    end

    assign w_dq  = QIDX_W'(PRIORITY_LEVELS) + QIDX_W'(i_item.device);
    assign w_tid = TASK_W'(i_item.task_id);
    assign w_cur = i_sched.cur_task;

    // Table reads: candidate pc/link, cur task pri; io_done: dev head link/pri
    always_comb begin
        o_rd_addr.pc = i_sched.head[w_l0];
        if (t_cmd'(i_item.command) == CMD_IO_DONE) begin
            o_rd_addr.link = i_sched.head[w_dq];
            o_rd_addr.pri  = i_sched.head[w_dq];
        end else begin
            o_rd_addr.link = i_sched.head[w_l0];
            o_rd_addr.pri  = w_cur;
        end
    end

    // Apply the command: pop, push, then dispatch
    always_comb begin
        t_sched            ns;
        t_wr               wr;
        logic              push_do;
        logic [QIDX_W-1:0] push_q;
        t_slot             push_t;
        logic              disp;
        logic              found;
        logic [LVL_W-1:0]  lv;
        t_slot             t;
        logic [PC_W-1:0]   run_pc;
        logic [ST_W-1:0]   status;

        ns      = i_sched;
        wr      = '0;
        push_do = 1'b0;
        push_q  = '0;
        push_t  = w_cur;
        disp    = 1'b0;
        found   = 1'b0;
        lv      = '0;
        t       = '0;
        run_pc  = i_item.cpu_pc;
        status  = ST_OK;

        unique case (t_cmd'(i_item.command))
            CMD_ADMIT: begin
                wr.pc_we    = 1'b1;
                wr.pc_addr  = w_tid;
                wr.pc_data  = '0;
                wr.pri_we   = 1'b1;
                wr.pri_addr = w_tid;
                wr.pri_data = PRI_W'(clamp_level(i_item.task_priority));
                push_do     = 1'b1;
                push_q      = QIDX_W'(clamp_level(i_item.task_priority));
                push_t      = w_tid;
            end
            CMD_PREEMPT, CMD_IO_WAIT: begin
                if (!i_sched.cur_idle) begin
                    wr.pc_we   = 1'b1;
                    wr.pc_addr = w_cur;
                    wr.pc_data = i_item.cpu_pc;
                    push_do    = 1'b1;
                    push_q     = (t_cmd'(i_item.command) == CMD_IO_WAIT) ? w_dq :
                                 QIDX_W'(clamp_level(i_rd_pri));
                end
                disp = 1'b1;
            end
            CMD_IO_DONE: begin
                if (i_sched.ne[w_dq]) begin
                    // Pop the device head and requeue it at its own level
                    t = i_sched.head[w_dq];
                    if (i_sched.head[w_dq] == i_sched.tail[w_dq]) begin
                        ns.ne[w_dq] = 1'b0;
                    end else begin
                        ns.head[w_dq] = i_rd_link;
                    end
                    push_do = 1'b1;
                    push_q  = QIDX_W'(clamp_level(i_rd_pri));
                    push_t  = t;
                end else begin
                    status = ST_IO_EMPTY;
                end
            end
            CMD_BLOCK, CMD_FINISH: begin
                if (!i_sched.cur_idle) begin
                    wr.pc_we   = 1'b1;
                    wr.pc_addr = w_cur;
                    wr.pc_data = i_item.cpu_pc;
                end
                disp = 1'b1;
            end
            default: begin
                status = ST_NO_CHANGE;
            end
        endcase

        // Append to the tail of the chosen queue
        if (push_do) begin
            if (ns.ne[push_q]) begin
                wr.link_we   = 1'b1;
                wr.link_addr = ns.tail[push_q];
                wr.link_data = push_t;
                ns.tail[push_q] = push_t;
            end else begin
                ns.head[push_q] = push_t;
                ns.tail[push_q] = push_t;
                ns.ne[push_q]   = 1'b1;
            end
        end

        // Start the head of the best ready level, forwarding this transaction's writes
        if (disp) begin
            for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
                if (ns.ne[l]) begin
                    found = 1'b1;
                    lv    = LVL_W'(l);
                end
            end
            if (found) begin
                t = ns.head[lv];
                if (ns.head[lv] == ns.tail[lv]) begin
                    ns.ne[lv] = 1'b0;
                end else if (wr.link_we && wr.link_addr == t) begin
                    ns.head[lv] = wr.link_data;
                end else begin
                    ns.head[lv] = i_rd_link;
                end
                ns.cur_task = t;
                ns.cur_idle = 1'b0;
                run_pc      = (wr.pc_we && wr.pc_addr == t) ? wr.pc_data : i_rd_pc;
            end else begin
                ns.cur_task = '0;
                ns.cur_idle = 1'b1;
                run_pc      = '0;
            end
        end

        o_sched = ns;
        o_wr    = wr;
        o_result.running_task = ns.cur_idle ? '0 : TID_W'(ns.cur_task);
        o_result.running_idle = ns.cur_idle;
        o_result.resume_pc    = run_pc;
        o_result.switched     = (i_sched.cur_idle != ns.cur_idle) ||
                                (!ns.cur_idle && i_sched.cur_task != ns.cur_task);
        o_result.status       = status;
    end

endmodule
